### src/aets_pkg.sv
package aets_pkg;

	// exposure table
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] INDEX_RESET = IDX_W'(80);

	typedef struct packed {
		logic [15:0] exposure;
		logic [7:0]  again;
		logic [5:0]  dgain;
		logic [15:0] ev;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// control passed from the lookup stage to the emitter
	typedef struct packed {
		logic valid;
		logic hold;
	} item_ctl_t;

	// configuration register indexes
	localparam logic [1:0] REG_TARGET_LUMA   = 2'd0;
	localparam logic [1:0] REG_TABLE_ENTRIES = 2'd1;
	localparam logic [1:0] REG_FPS_MODE      = 2'd2;

	localparam logic [7:0] TARGET_RESET  = 8'd60;
	localparam logic [8:0] ENTRIES_RESET = 9'd256;
	localparam logic [1:0] FPS_RESET     = 2'd1;
	localparam logic [7:0] LUMA_RESET    = 8'd60;

	// control loop bands
	localparam logic [7:0] JUMP_LIMIT = 8'd20;
	localparam logic [7:0] HOLD_BAND  = 8'd6;
	localparam logic [7:0] DEAD_BAND  = 8'd4;
	localparam logic [7:0] ERR_BIG    = 8'd40;
	localparam logic [7:0] ERR_MID    = 8'd20;
	localparam logic [7:0] ERR_SMALL  = 8'd10;

	// frame length thresholds on four times the exposure
	localparam logic [17:0] LONG_30 = 18'd33332;
	localparam logic [17:0] LONG_25 = 18'd40000;
	localparam logic [17:0] LONG_60 = 18'd16667;
	localparam logic [17:0] LONG_50 = 18'd20000;
	localparam logic [15:0] DFLT_FAST_MODE = 16'h02ee;
	localparam logic [15:0] DFLT_PAL_MODE  = 16'h0384;

	// rows = floor(y / 100) via reciprocal, exact for y below 2^27 / 72
	localparam logic [20:0] RECIP       = 21'd1342178;
	localparam int          RECIP_SHIFT = 27;

	// sensor registers
	localparam logic [7:0] SR_VTS_LO   = 8'h22;
	localparam logic [7:0] SR_VTS_HI   = 8'h23;
	localparam logic [7:0] SR_AG_PAGE  = 8'hc0;
	localparam logic [7:0] SR_AG_VAL   = 8'hc1;
	localparam logic [7:0] SR_SH_SEL0  = 8'hc2;
	localparam logic [7:0] SR_SH_VAL0  = 8'hc3;
	localparam logic [7:0] SR_SH_SEL1  = 8'hc4;
	localparam logic [7:0] SR_SH_VAL1  = 8'hc5;
	localparam logic [7:0] SR_DG_PAGE  = 8'hc6;
	localparam logic [7:0] SR_DG_VAL   = 8'hc7;
	localparam logic [7:0] AG_PAGE_VAL = 8'h00;
	localparam logic [7:0] DG_PAGE_VAL = 8'h0d;
	localparam logic [7:0] DG_OR_MASK  = 8'h40;
	localparam logic [7:0] SH_SEL0_VAL = 8'h01;
	localparam logic [7:0] SH_SEL1_VAL = 8'h02;

	// result slots, emitted lowest first
	localparam int NSLOT = 11;
	localparam logic [3:0] SLOT_FL0   = 4'd0;
	localparam logic [3:0] SLOT_FL1   = 4'd1;
	localparam logic [3:0] SLOT_AG0   = 4'd2;
	localparam logic [3:0] SLOT_AG1   = 4'd3;
	localparam logic [3:0] SLOT_DG0   = 4'd4;
	localparam logic [3:0] SLOT_DG1   = 4'd5;
	localparam logic [3:0] SLOT_SH0   = 4'd6;
	localparam logic [3:0] SLOT_SH1   = 4'd7;
	localparam logic [3:0] SLOT_SH2   = 4'd8;
	localparam logic [3:0] SLOT_SH3   = 4'd9;
	localparam logic [3:0] SLOT_FINAL = 4'd10;

endpackage

### src/aets_ram.sv
module aets_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### src/aets_emit.sv
module aets_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  aets_pkg::item_ctl_t ctl,
	input  aets_pkg::entry_t    entry,
	input  logic [1:0]          fps_mode,
	output logic                s2_free,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          reg_addr,
	output logic [7:0]          reg_data,
	output logic                reg_write,
	output logic [15:0]         ev_report,
	output logic                last
);

	localparam logic [aets_pkg::NSLOT-1:0] FINAL_ONLY =
		aets_pkg::NSLOT'(1) << aets_pkg::SLOT_FINAL;

	logic [aets_pkg::NSLOT-1:0] pend_q;
	logic        long_s3;
	logic [15:0] rows_s3;
	logic [15:0] dflt_s3;
	logic [7:0]  again_s3;
	logic [5:0]  dgain_s3;
	logic [15:0] ev_s3;

	logic [7:0]  sh_again_q;
	logic [5:0]  sh_dgain_q;
	logic [15:0] sh_exp_q;
	logic        again_ok_q;
	logic        dgain_ok_q;
	logic        exp_ok_q;

	logic [19:0] x9;
	logic [20:0] y;
	logic [42:0] prod;
	logic [15:0] rows;
	logic [17:0] t4;
	logic        long_frame;
	logic [15:0] dflt;
	logic        wr_again;
	logic        wr_dgain;
	logic        wr_exp;
	logic [aets_pkg::NSLOT-1:0] mask;
	logic        load;
	logic [3:0]  slot;

	// rows = 4 * e * pclk / 0x640, i.e. 9e/100 on the slow clock, 18e/100 on the fast one
	assign x9   = 20'({entry.exposure, 3'b000}) + 20'(entry.exposure);
	assign y    = fps_mode[0] ? {1'b0, x9} : {x9, 1'b0};
	assign prod = {22'd0, y} * {22'd0, aets_pkg::RECIP};
	assign rows = prod[aets_pkg::RECIP_SHIFT+15:aets_pkg::RECIP_SHIFT];
	assign t4   = {entry.exposure, 2'b00};
	assign dflt = fps_mode[1] ? aets_pkg::DFLT_PAL_MODE : aets_pkg::DFLT_FAST_MODE;

	always_comb begin
		unique case (fps_mode)
			2'd0:    long_frame = t4 >= aets_pkg::LONG_60;
			2'd1:    long_frame = t4 > aets_pkg::LONG_30;
			2'd2:    long_frame = t4 >= aets_pkg::LONG_50;
			default: long_frame = t4 > aets_pkg::LONG_25;
		endcase
	end

	assign wr_again = !again_ok_q || (sh_again_q != entry.again);
	assign wr_dgain = !dgain_ok_q || (sh_dgain_q != entry.dgain);
	assign wr_exp   = !exp_ok_q || (sh_exp_q != entry.exposure);

	always_comb begin
		mask = FINAL_ONLY;
		if (!ctl.hold) begin
			mask[aets_pkg::SLOT_FL0] = 1'b1;
			mask[aets_pkg::SLOT_FL1] = 1'b1;
			mask[aets_pkg::SLOT_AG0] = wr_again;
			mask[aets_pkg::SLOT_AG1] = wr_again;
			mask[aets_pkg::SLOT_DG0] = wr_dgain;
			mask[aets_pkg::SLOT_DG1] = wr_dgain;
			mask[aets_pkg::SLOT_SH0] = wr_exp;
			mask[aets_pkg::SLOT_SH1] = wr_exp;
			mask[aets_pkg::SLOT_SH2] = wr_exp;
			mask[aets_pkg::SLOT_SH3] = wr_exp;
		end
	end

	// take the next item when empty or as the final result of the current one leaves
	assign load    = ctl.valid && ((pend_q == '0) || (out_ready && (pend_q == FINAL_ONLY)));
	assign s2_free = !ctl.valid || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			again_ok_q <= 1'b0;
			dgain_ok_q <= 1'b0;
			exp_ok_q   <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= mask;
			end else if (out_valid && out_ready) begin
				pend_q <= pend_q & (pend_q - aets_pkg::NSLOT'(1));
			end
			if (load && !ctl.hold) begin
				again_ok_q <= 1'b1;
				dgain_ok_q <= 1'b1;
				exp_ok_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			long_s3  <= long_frame;
			rows_s3  <= rows;
			dflt_s3  <= dflt;
			again_s3 <= entry.again;
			dgain_s3 <= entry.dgain;
			ev_s3    <= entry.ev;
			if (!ctl.hold) begin
				sh_again_q <= entry.again;
				sh_dgain_q <= entry.dgain;
				sh_exp_q   <= entry.exposure;
			end
		end
	end

	// lowest pending slot goes out first
	always_comb begin
		slot = aets_pkg::SLOT_FINAL;
		for (int i = aets_pkg::NSLOT - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				slot = 4'(i);
			end
		end
	end

	assign out_valid = |pend_q;

	always_comb begin
		reg_addr  = '0;
		reg_data  = '0;
		reg_write = 1'b1;
		ev_report = '0;
		last      = 1'b0;
		unique case (slot)
			aets_pkg::SLOT_FL0: begin
				reg_addr = long_s3 ? aets_pkg::SR_VTS_LO : aets_pkg::SR_VTS_HI;
				reg_data = long_s3 ? rows_s3[7:0] : dflt_s3[15:8];
			end
			aets_pkg::SLOT_FL1: begin
				reg_addr = long_s3 ? aets_pkg::SR_VTS_HI : aets_pkg::SR_VTS_LO;
				reg_data = long_s3 ? rows_s3[15:8] : dflt_s3[7:0];
			end
			aets_pkg::SLOT_AG0: begin
				reg_addr = aets_pkg::SR_AG_PAGE;
				reg_data = aets_pkg::AG_PAGE_VAL;
			end
			aets_pkg::SLOT_AG1: begin
				reg_addr = aets_pkg::SR_AG_VAL;
				reg_data = again_s3;
			end
			aets_pkg::SLOT_DG0: begin
				reg_addr = aets_pkg::SR_DG_PAGE;
				reg_data = aets_pkg::DG_PAGE_VAL;
			end
			aets_pkg::SLOT_DG1: begin
				reg_addr = aets_pkg::SR_DG_VAL;
				reg_data = aets_pkg::DG_OR_MASK | {2'b00, dgain_s3};
			end
			aets_pkg::SLOT_SH0: begin
				reg_addr = aets_pkg::SR_SH_SEL0;
				reg_data = aets_pkg::SH_SEL0_VAL;
			end
			aets_pkg::SLOT_SH1: begin
				reg_addr = aets_pkg::SR_SH_VAL0;
				reg_data = rows_s3[7:0];
			end
			aets_pkg::SLOT_SH2: begin
				reg_addr = aets_pkg::SR_SH_SEL1;
				reg_data = aets_pkg::SH_SEL1_VAL;
			end
			aets_pkg::SLOT_SH3: begin
				reg_addr = aets_pkg::SR_SH_VAL1;
				reg_data = rows_s3[15:8];
			end
			default: begin
				reg_write = 1'b0;
				ev_report = ev_s3;
				last      = 1'b1;
			end
		endcase
	end

endmodule

### src/auto_exposure_table_stepper_top.sv
// auto exposure table stepper
//
// input channel (in_valid / in_ready): one transaction per item. req_type 0 carries a
// frame mean luma; req_type 1 writes one exposure table entry and gives no result.
// output channel (out_valid / out_ready): for each luma item, a run of sensor register
// writes (reg_write 1) followed by one final result (last 1, ev_report set). A held,
// stable exposure gives the final result alone.
// configuration: cfg_we with cfg_addr 0 target luma, 1 table entries, 2 fps mode;
// write only while no item is in flight.
//
// a taken luma item is registered in the input stage, read from the table, then
// loaded into the emitter; each step waits while the next is full. An item gives one
// to eleven results; table writes are taken one per cycle unless a luma item waits in
// the input stage. The next item is looked up while the current one drains, so queued
// items leave no gaps. The table is a single port memory: one write or one read per cycle.
//
// reset clears the loop state and pipeline valids and invalidates the shadow registers;
// table contents are undefined until written. When out_ready is low the current result
// holds and the stages behind it fill up, then in_ready drops.
module auto_exposure_table_stepper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  luma,
	input  logic [7:0]  entry_index,
	input  logic [15:0] entry_exposure,
	input  logic [7:0]  entry_analog_gain,
	input  logic [5:0]  entry_digital_gain,
	input  logic [15:0] entry_ev,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  reg_addr,
	output logic [7:0]  reg_data,
	output logic        reg_write,
	output logic [15:0] ev_report,
	output logic        last
);

	localparam int IW = aets_pkg::IDX_W;

	// configuration
	logic [7:0] target_q;
	logic [8:0] entries_q;
	logic [1:0] fps_q;

	// loop state
	logic [7:0]    smooth_q;
	logic          stable_q;
	logic [IW-1:0] index_q;

	// input stage
	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  luma_s1;
	logic [7:0]  entry_index_s1;
	logic [15:0] entry_exposure_s1;
	logic [7:0]  entry_analog_gain_s1;
	logic [5:0]  entry_digital_gain_s1;
	logic [15:0] entry_ev_s1;

	// lookup stage
	logic valid_s2;
	logic hold_s2;

	logic          s1_go;
	logic          s2_free;
	logic [7:0]    jump;
	logic [9:0]    avg_sum;
	logic [7:0]    mean;
	logic [7:0]    err;
	logic          hold;
	logic [2:0]    step_mag;
	logic signed [IW+1:0] base;
	logic signed [IW+1:0] cand;
	logic [IW-1:0] max_idx;
	logic [IW-1:0] clamped;
	logic [IW-1:0] next_index;
	logic          ram_we;
	logic          ram_re;
	logic [IW-1:0] ram_addr;
	aets_pkg::entry_t    ram_wdata;
	aets_pkg::entry_t    ram_rdata;
	aets_pkg::item_ctl_t ctl_s2;

	// table writes never wait for the emitter
	assign s1_go    = valid_s1 && (req_type_s1 || s2_free);
	assign in_ready = !valid_s1 || s1_go;

	// smoothing
	assign jump    = (luma_s1 > smooth_q) ? (luma_s1 - smooth_q) : (smooth_q - luma_s1);
	assign avg_sum = 10'({luma_s1, 1'b0}) + 10'(luma_s1) + 10'(smooth_q) + 10'd2;
	assign mean    = (jump > aets_pkg::JUMP_LIMIT) ? luma_s1 : avg_sum[9:2];
	assign err     = (mean > target_q) ? (mean - target_q) : (target_q - mean);
	assign hold    = stable_q && (err <= aets_pkg::HOLD_BAND);

	always_comb begin
		if (err > aets_pkg::ERR_BIG) begin
			step_mag = 3'd6;
		end else if (err > aets_pkg::ERR_MID) begin
			step_mag = 3'd4;
		end else if (err > aets_pkg::ERR_SMALL) begin
			step_mag = 3'd2;
		end else begin
			step_mag = 3'd1;
		end
	end

	assign base = $signed({2'b00, index_q});

	always_comb begin
		if (err < aets_pkg::DEAD_BAND) begin
			cand = base;
		end else if (mean > target_q) begin
			cand = base - $signed((IW + 2)'(step_mag));
		end else begin
			cand = base + $signed((IW + 2)'(step_mag));
		end
	end

	always_comb begin
		if (int'(entries_q) > aets_pkg::TABLE_DEPTH) begin
			max_idx = IW'(aets_pkg::TABLE_DEPTH - 1);
		end else if (entries_q == 9'd0) begin
			max_idx = '0;
		end else begin
			max_idx = IW'(entries_q - 9'd1);
		end
	end

	always_comb begin
		if (cand < 0) begin
			clamped = '0;
		end else if (cand > $signed({2'b00, max_idx})) begin
			clamped = max_idx;
		end else begin
			clamped = cand[IW-1:0];
		end
	end

	assign next_index = hold ? index_q : clamped;

	assign ram_we    = s1_go && req_type_s1 && (int'(entry_index_s1) < aets_pkg::TABLE_DEPTH);
	assign ram_re    = s1_go && !req_type_s1;
	assign ram_addr  = req_type_s1 ? IW'(entry_index_s1) : next_index;
	assign ram_wdata = '{
		exposure: entry_exposure_s1,
		again:    entry_analog_gain_s1,
		dgain:    entry_digital_gain_s1,
		ev:       entry_ev_s1
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= aets_pkg::TARGET_RESET;
			entries_q <= aets_pkg::ENTRIES_RESET;
			fps_q     <= aets_pkg::FPS_RESET;
			smooth_q  <= aets_pkg::LUMA_RESET;
			stable_q  <= 1'b0;
			index_q   <= aets_pkg::INDEX_RESET;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					aets_pkg::REG_TARGET_LUMA:   target_q  <= cfg_data[7:0];
					aets_pkg::REG_TABLE_ENTRIES: entries_q <= cfg_data;
					aets_pkg::REG_FPS_MODE:      fps_q     <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			if (ram_re) begin
				smooth_q <= mean;
				index_q  <= next_index;
				if (!hold) begin
					stable_q <= (err < aets_pkg::DEAD_BAND);
				end
			end

			if (ram_re) begin
				valid_s2 <= 1'b1;
			end else if (s2_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1           <= req_type;
			luma_s1               <= luma;
			entry_index_s1        <= entry_index;
			entry_exposure_s1     <= entry_exposure;
			entry_analog_gain_s1  <= entry_analog_gain;
			entry_digital_gain_s1 <= entry_digital_gain;
			entry_ev_s1           <= entry_ev;
		end
		if (ram_re) begin
			hold_s2 <= hold;
		end
	end

	aets_ram #(
		.WIDTH (aets_pkg::ENTRY_W),
		.DEPTH (aets_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign ctl_s2 = '{valid: valid_s2, hold: hold_s2};

	aets_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s2),
		.entry     (ram_rdata),
		.fps_mode  (fps_q),
		.s2_free   (s2_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.reg_addr  (reg_addr),
		.reg_data  (reg_data),
		.reg_write (reg_write),
		.ev_report (ev_report),
		.last      (last)
	);

endmodule

### tb/aets_register_checker.sv
`timescale 1ns / 1ps

module aets_register_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  luma,
	input  logic [7:0]  entry_index,
	input  logic [15:0] entry_exposure,
	input  logic [7:0]  entry_analog_gain,
	input  logic [5:0]  entry_digital_gain,
	input  logic [15:0] entry_ev,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  reg_data,
	input  logic        reg_write,
	input  logic [15:0] ev_report,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          checked
);

	localparam int LUMA_JUMP   = 20;
	localparam int HOLD_WINDOW = 6;
	localparam int DEAD_ZONE   = 4;
	localparam int BIG_ERR     = 40;
	localparam int MID_ERR     = 20;
	localparam int SMALL_ERR   = 10;
	localparam int ROW_CLK     = 'h640;
	localparam int LONG_30FPS  = 33332;
	localparam int LONG_25FPS  = 40000;
	localparam int LONG_60FPS  = 16667;
	localparam int LONG_50FPS  = 20000;
	localparam int VTS_NTSC    = 'h2ee;
	localparam int VTS_PAL     = 'h384;

	localparam logic [7:0] VTS_LO  = 8'h22;
	localparam logic [7:0] VTS_HI  = 8'h23;
	localparam logic [7:0] AG_PAGE = 8'hc0;
	localparam logic [7:0] AG_VAL  = 8'hc1;
	localparam logic [7:0] SH_SEL0 = 8'hc2;
	localparam logic [7:0] SH_VAL0 = 8'hc3;
	localparam logic [7:0] SH_SEL1 = 8'hc4;
	localparam logic [7:0] SH_VAL1 = 8'hc5;
	localparam logic [7:0] DG_PAGE = 8'hc6;
	localparam logic [7:0] DG_VAL  = 8'hc7;

	typedef struct packed {
		logic [7:0]  addr;
		logic [7:0]  data;
		logic        wr;
		logic [15:0] ev;
		logic        fin;
	} sensor_txn_t;

	sensor_txn_t sensor_txns_due [$];

	aets_pkg::entry_t lut [aets_pkg::TABLE_DEPTH];

	logic [7:0]  smoothed    = 8'd60;
	bit          settled     = 1'b0;
	int          ae_index    = 80;
	logic [7:0]  target      = 8'd60;
	logic [8:0]  entries_cfg = 9'd256;
	logic [1:0]  fps_cfg     = 2'd1;
	logic [7:0]  ag_shadow;
	logic [5:0]  dg_shadow;
	logic [15:0] exp_shadow;
	bit          ag_known, dg_known, exp_known;

	task automatic due_write(input logic [7:0] a, input logic [7:0] d);
		sensor_txns_due.push_back('{a, d, 1'b1, 16'h0, 1'b0});
	endtask

	task automatic due_final(input logic [15:0] ev);
		sensor_txns_due.push_back('{8'h0, 8'h0, 1'b0, ev, 1'b1});
	endtask

	task automatic predict_luma_step(input logic [7:0] l);
		int diff, err, stride, limit, pclk, rows, dflt, t4;
		bit long_frame;
		aets_pkg::entry_t e;
		diff = (l > smoothed) ? l - smoothed : smoothed - l;
		if (diff > LUMA_JUMP)
			smoothed = l;
		else
			smoothed = 8'((3 * int'(l) + int'(smoothed) + 2) >> 2);
		err = (smoothed > target) ? smoothed - target : target - smoothed;

		// stable and close enough: nothing to write, only the ev report
		if (err <= HOLD_WINDOW && settled) begin
			due_final(lut[ae_index].ev);
			return;
		end

		if (err >= DEAD_ZONE) begin
			stride = err > BIG_ERR ? 6 : err > MID_ERR ? 4 : err > SMALL_ERR ? 2 : 1;
			ae_index += (smoothed > target) ? -stride : stride;
			settled = 1'b0;
		end else begin
			settled = 1'b1;
		end

		limit = int'(entries_cfg);
		if (limit > aets_pkg::TABLE_DEPTH)
			limit = aets_pkg::TABLE_DEPTH;
		if (limit < 1)
			limit = 1;
		if (ae_index < 0)
			ae_index = 0;
		else if (ae_index >= limit)
			ae_index = limit - 1;

		e = lut[ae_index];
		t4 = int'(e.exposure) * 4;
		pclk = fps_cfg[0] ? 36 : 72;
		rows = t4 * pclk / ROW_CLK;
		dflt = fps_cfg[1] ? VTS_PAL : VTS_NTSC;
		case (fps_cfg)
			2'd0: long_frame = t4 >= LONG_60FPS;
			2'd1: long_frame = t4 > LONG_30FPS;
			2'd2: long_frame = t4 >= LONG_50FPS;
			default: long_frame = t4 > LONG_25FPS;
		endcase

		// long frames go low byte first, default lengths high byte first
		if (long_frame) begin
			due_write(VTS_LO, rows[7:0]);
			due_write(VTS_HI, rows[15:8]);
		end else begin
			due_write(VTS_HI, dflt[15:8]);
			due_write(VTS_LO, dflt[7:0]);
		end
		if (!ag_known || ag_shadow != e.again) begin
			ag_known = 1'b1;
			ag_shadow = e.again;
			due_write(AG_PAGE, 8'h00);
			due_write(AG_VAL, e.again);
		end
		if (!dg_known || dg_shadow != e.dgain) begin
			dg_known = 1'b1;
			dg_shadow = e.dgain;
			due_write(DG_PAGE, 8'h0d);
			due_write(DG_VAL, {2'b01, e.dgain});
		end
		if (!exp_known || exp_shadow != e.exposure) begin
			exp_known = 1'b1;
			exp_shadow = e.exposure;
			due_write(SH_SEL0, 8'h01);
			due_write(SH_VAL0, rows[7:0]);
			due_write(SH_SEL1, 8'h02);
			due_write(SH_VAL1, rows[15:8]);
		end
		due_final(e.ev);
	endtask

	task automatic field_match(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sensor_txn_t w;
		if (!arst_n) begin
			smoothed = 8'd60;
			settled = 1'b0;
			ae_index = 80;
			target = 8'd60;
			entries_cfg = 9'd256;
			fps_cfg = 2'd1;
			ag_known = 1'b0;
			dg_known = 1'b0;
			exp_known = 1'b0;
			sensor_txns_due.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (sensor_txns_due.size() == 0) begin
					$error("result transaction with nothing outstanding: addr 0x%0h last %0b",
						reg_addr, last);
					errors++;
				end else begin
					w = sensor_txns_due.pop_front();
					field_match("reg_addr", w.addr, reg_addr);
					field_match("reg_data", w.data, reg_data);
					field_match("reg_write", w.wr, reg_write);
					field_match("ev_report", w.ev, ev_report);
					field_match("last", w.fin, last);
					checked++;
				end
			end
			if (in_valid && in_ready) begin
				if (req_type)
					lut[entry_index] = '{entry_exposure, entry_analog_gain,
						entry_digital_gain, entry_ev};
				else
					predict_luma_step(luma);
			end
			if (cfg_we) begin
				case (cfg_addr)
					aets_pkg::REG_TARGET_LUMA:   target = cfg_data[7:0];
					aets_pkg::REG_TABLE_ENTRIES: entries_cfg = cfg_data;
					aets_pkg::REG_FPS_MODE:      fps_cfg = cfg_data[1:0];
					default: ;
				endcase
			end
			pending = sensor_txns_due.size();
		end
	end

endmodule

### tb/auto_exposure_table_stepper_top_tb.sv
`timescale 1ns / 1ps

module auto_exposure_table_stepper_top_tb;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int LONG_HOLD   = 300;
	localparam int PHASES      = 4;
	localparam int PHASE_ITEMS = 30;

	typedef struct {
		logic        rt;
		logic [7:0]  luma;
		logic [7:0]  idx;
		logic [15:0] expo;
		logic [7:0]  ag;
		logic [5:0]  dg;
		logic [15:0] ev;
	} ae_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [8:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  luma;
	logic [7:0]  entry_index;
	logic [15:0] entry_exposure;
	logic [7:0]  entry_analog_gain;
	logic [5:0]  entry_digital_gain;
	logic [15:0] entry_ev;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  reg_addr;
	logic [7:0]  reg_data;
	logic        reg_write;
	logic [15:0] ev_report;
	logic        last;

	int fails, pending, checked;
	int luma_sent = 0;
	int entries_sent = 0;
	int cur_target = 60;
	bit calm = 1'b0;
	bit hold_wanted = 1'b0;
	bit hold_active = 1'b0;

	// exposures either side of each frame length threshold
	logic [15:0] threshold_exposures [10] = '{16'd4166, 16'd4167, 16'd4999, 16'd5000,
		16'd8333, 16'd8334, 16'd10000, 16'd10001, 16'd0, 16'hffff};

	// settle, hold, creep, then hard jumps both ways to hit the clamps
	int directed_luma [24] = '{60, 60, 60, 66, 70, 80, 100, 255, 255, 255, 0, 0, 0, 0,
		0, 0, 0, 40, 59, 61, 60, 60, 81, 39};

	always #1 clk = ~clk;

	auto_exposure_table_stepper_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .luma(luma), .entry_index(entry_index),
		.entry_exposure(entry_exposure), .entry_analog_gain(entry_analog_gain),
		.entry_digital_gain(entry_digital_gain), .entry_ev(entry_ev),
		.out_valid(out_valid), .out_ready(out_ready),
		.reg_addr(reg_addr), .reg_data(reg_data), .reg_write(reg_write),
		.ev_report(ev_report), .last(last)
	);

	aets_register_checker reg_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .luma(luma), .entry_index(entry_index),
		.entry_exposure(entry_exposure), .entry_analog_gain(entry_analog_gain),
		.entry_digital_gain(entry_digital_gain), .entry_ev(entry_ev),
		.out_valid(out_valid), .out_ready(out_ready),
		.reg_addr(reg_addr), .reg_data(reg_data), .reg_write(reg_write),
		.ev_report(ev_report), .last(last),
		.errors(fails), .pending(pending), .checked(checked)
	);

	initial begin
		#1000000;
		$display("auto_exposure_table_stepper_top_tb: errors");
		$finish;
	end

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				hold_active = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_active = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 60)) @(negedge clk);
			end
		end
	end

	function automatic ae_item_t entry_item(int i);
		ae_item_t it;
		it.rt = 1'b1;
		it.luma = 8'($urandom);
		it.idx = 8'(i);
		it.expo = ($urandom_range(0, 2) == 0) ?
			threshold_exposures[$urandom_range(0, 9)] : 16'($urandom);
		// one shared value per gain so neighbouring entries often leave the shadows alone
		it.ag = $urandom_range(0, 1) ? 8'h20 : 8'($urandom);
		it.dg = $urandom_range(0, 1) ? 6'h05 : 6'($urandom);
		it.ev = 16'($urandom);
		if (i == 0) begin
			it.expo = 16'h0;
			it.ag = 8'h0;
			it.dg = 6'h0;
			it.ev = 16'h0;
		end else if (i == 255) begin
			it.expo = 16'hffff;
			it.ag = 8'hff;
			it.dg = 6'h3f;
			it.ev = 16'hffff;
		end
		return it;
	endfunction

	function automatic ae_item_t luma_item(int l);
		ae_item_t it;
		it = entry_item($urandom_range(1, 254));
		it.rt = 1'b0;
		it.luma = 8'(l);
		return it;
	endfunction

	function automatic int pick_luma();
		int r, v;
		r = $urandom_range(0, 9);
		if (r == 0)
			v = $urandom_range(0, 255);
		else if (r <= 4)
			v = cur_target + int'($urandom_range(0, 8)) - 4;
		else
			v = cur_target + int'($urandom_range(0, 100)) - 50;
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return v;
	endfunction

	task automatic offer(input ae_item_t it);
		req_type <= it.rt;
		luma <= it.luma;
		entry_index <= it.idx;
		entry_exposure <= it.expo;
		entry_analog_gain <= it.ag;
		entry_digital_gain <= it.dg;
		entry_ev <= it.ev;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (it.rt)
			entries_sent++;
		else
			luma_sent++;
	endtask

	task automatic sender_gap();
		if (!calm && !hold_active && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	// a table write gives no result, so allow the pipe time to finish after the queue empties
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(int tgt, int cnt, int mode);
		cfg_we <= 1'b1;
		cfg_addr <= aets_pkg::REG_TARGET_LUMA;
		cfg_data <= 9'(tgt);
		@(negedge clk);
		cfg_addr <= aets_pkg::REG_TABLE_ENTRIES;
		cfg_data <= 9'(cnt);
		@(negedge clk);
		cfg_addr <= aets_pkg::REG_FPS_MODE;
		cfg_data <= 9'(mode);
		@(negedge clk);
		cfg_addr <= REG_SPARE;
		cfg_data <= 9'($urandom_range(0, 511));
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_target = tgt;
	endtask

	initial begin
		int tgt, cnt, mode;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		luma = '0;
		entry_index = '0;
		entry_exposure = '0;
		entry_analog_gain = '0;
		entry_digital_gain = '0;
		entry_ev = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure(60, 256, 1);
		// fill the whole table so no step ever reads an unwritten entry
		for (int i = 0; i < 256; i++) begin
			offer(entry_item(i));
			sender_gap();
		end
		foreach (directed_luma[i]) begin
			offer(luma_item(directed_luma[i]));
			sender_gap();
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin tgt = 0;   cnt = 1;   mode = 0; end
				1: begin tgt = 255; cnt = 511; mode = 2; end
				2: begin tgt = 128; cnt = 0;   mode = 3; end
				3: begin tgt = 60;  cnt = 256; mode = 1; end
				default: begin
					tgt = $urandom_range(0, 255);
					cnt = $urandom_range(1, 300);
					mode = $urandom_range(0, 3);
				end
			endcase
			configure(tgt, cnt, mode);
			if (p == 1)
				hold_wanted = 1'b1;
			if (p == PHASES - 1)
				calm = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 6) == 0)
					offer(entry_item($urandom_range(0, 255)));
				else
					offer(luma_item(pick_luma()));
				sender_gap();
			end
		end
		settle();

		$display("covered %0d luma steps and %0d table loads across %0d register settings",
			luma_sent, entries_sent, PHASES + 1);
		$display("%0d result transactions compared, %0d mismatches", checked, fails);
		if (fails == 0)
			$display("auto_exposure_table_stepper_top_tb: clean");
		else
			$display("auto_exposure_table_stepper_top_tb: errors");
		$finish;
	end

endmodule

### filelist.f
src/aets_pkg.sv
src/aets_ram.sv
src/aets_emit.sv
src/auto_exposure_table_stepper_top.sv
tb/aets_register_checker.sv
tb/auto_exposure_table_stepper_top_tb.sv
